FILE: rtl/cartridge_bus_register_decoder_macros.svh
// ----------------------------------------------------------------------------
// Cartridge bus register decoder assertion macros
// Shared assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BUS_REGISTER_DECODER_MACROS_SVH
`define CARTRIDGE_BUS_REGISTER_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define CBRD_ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("cbrd assertion failed");
`define CBRD_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("cbrd assertion failed");
`else
`define CBRD_ASSERT_SAME(label, cond, prop)
`define CBRD_ASSERT_NEXT(label, cond, prop)
`endif
`endif

FILE: rtl/cbrd_pkg.sv
// ----------------------------------------------------------------------------
// cbrd_pkg
// Sizes, codes and helpers of the cartridge bus register decoder.
// ----------------------------------------------------------------------------
package cbrd_pkg;

  // image size is a power of two
  localparam int IMAGE_SIZE  = 32768;
  localparam int BUFFER_SIZE = 512;

  localparam int IMG_AW = $clog2(IMAGE_SIZE);
  localparam int BUF_AW = $clog2(BUFFER_SIZE);
  localparam int IDX_W  = $clog2(BUFFER_SIZE + 1);

  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int CMD_W     = 3;
  localparam int POS_W     = 10;
  localparam int SAM_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int OFFSET_W  = 15;

  localparam int MAP_TYPE_BIT = 15;

  // FFC0..FFDF share these upper address bits
  localparam logic [ADDR_W-6:0]   SAM_PREFIX  = 11'h7FE;
  localparam logic [ADDR_W-1:0]   NO_TRACK    = 16'hFFFF;
  localparam logic [DATA_W-1:0]   IMAGE_FILL  = 8'h01;

  typedef enum logic [CMD_W-1:0] {
    CMD_BUS_READ     = 3'd0,
    CMD_BUS_WRITE    = 3'd1,
    CMD_LOAD_READ    = 3'd2,
    CMD_PEEK_WRITE   = 3'd3,
    CMD_LOAD_BUFFER  = 3'd4,
    CMD_SET_INDEX    = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMMAND_ADDRESS    = 3'd0,
    CFG_LATCH_ADDRESS      = 3'd1,
    CFG_WRITE_DATA_ADDRESS = 3'd2,
    CFG_READ_DATA_ADDRESS  = 3'd3,
    CFG_TEST_ADDRESS       = 3'd4,
    CFG_DATA_OUT_OFFSET    = 3'd5,
    CFG_ROM_BASE_BITS      = 3'd6,
    CFG_RESET_VECTOR       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   command_address;
    logic [ADDR_W-1:0]   latch_address;
    logic [ADDR_W-1:0]   write_data_address;
    logic [ADDR_W-1:0]   read_data_address;
    logic [ADDR_W-1:0]   test_address;
    logic [OFFSET_W-1:0] data_out_offset;
    logic [ADDR_W-1:0]   rom_base_bits;
    logic [ADDR_W-1:0]   reset_vector;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    command_address:    16'hFF00,
    latch_address:      16'hFF01,
    write_data_address: 16'hFF02,
    read_data_address:  16'hFF03,
    test_address:       16'hFF04,
    data_out_offset:    15'h7F03,
    rom_base_bits:      16'h8000,
    reset_vector:       16'hFFFE
  };

  function automatic logic [IMG_AW-1:0] image_slot(input logic [ADDR_W-1:0] a);
    return a[IMG_AW-1:0];
  endfunction

endpackage

FILE: rtl/cbrd_if.sv
// ----------------------------------------------------------------------------
// cbrd channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbrd_req_if;
  logic                          valid;
  logic                          ready;
  logic [cbrd_pkg::CMD_W-1:0]    cmd;
  logic [cbrd_pkg::ADDR_W-1:0]   address;
  logic [cbrd_pkg::DATA_W-1:0]   data;
  logic [cbrd_pkg::POS_W-1:0]    buffer_position;

  modport source (output valid, cmd, address, data, buffer_position, input ready);
  modport sink   (input valid, cmd, address, data, buffer_position, output ready);
endinterface

interface cbrd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cbrd_pkg::DATA_W-1:0]   rd_byte;
  logic                          command_strobe;
  logic [cbrd_pkg::DATA_W-1:0]   command_value;
  logic                          latch_strobe;
  logic [cbrd_pkg::DATA_W-1:0]   latch_value;
  logic                          test_strobe;
  logic [cbrd_pkg::DATA_W-1:0]   test_value;
  logic [cbrd_pkg::SAM_W-1:0]    sam_state;
  logic                          map_type;
  logic                          reset_seen;
  logic [cbrd_pkg::POS_W-1:0]    index_now;

  modport source (output valid, rd_byte, command_strobe, command_value, latch_strobe,
                  latch_value, test_strobe, test_value, sam_state, map_type, reset_seen,
                  index_now, input ready);
  modport sink   (input valid, rd_byte, command_strobe, command_value, latch_strobe,
                  latch_value, test_strobe, test_value, sam_state, map_type, reset_seen,
                  index_now, output ready);
endinterface

FILE: rtl/cartridge_bus_register_decoder.sv
// ----------------------------------------------------------------------------
// cartridge_bus_register_decoder
// Decodes CPU bus accesses and host commands against two byte images,
// a data buffer and a small set of cartridge registers.
// ----------------------------------------------------------------------------
// Usage: requests enter on req (cmd, address, data, buffer_position) and one
// result per request leaves on rsp. Registers are written through cfg_wr_en,
// cfg_index and cfg_data; the user must write them only while no request is
// in flight, as the block itself does not enforce this. Each request reads
// the image and buffer memories at acceptance; in S_EXEC it is computed,
// written back and its result loaded into the result register, which waits
// while a previous result still holds in rsp. Each image has a single memory
// port, so no new request is accepted until the previous one leaves S_EXEC.
// A new request is taken while the previous result still waits in rsp.
// After reset both images are filled with 0x01, one entry a cycle, over all
// IMAGE_SIZE (32768) entries; req.ready stays low until it is done.
// Register writes are taken during that pass as well.
// When the receiver stalls, the finished result holds in rsp and the next
// request, once accepted, waits after its read cycle with nothing written.
// ----------------------------------------------------------------------------
`include "cartridge_bus_register_decoder_macros.svh"

module cartridge_bus_register_decoder (
  input  logic                               clk,
  input  logic                               rst,
  cbrd_req_if.sink                           req,
  cbrd_rsp_if.source                         rsp,
  input  logic                               cfg_wr_en,
  input  logic [cbrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbrd_pkg::CFG_W-1:0]         cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  typedef struct packed {
    logic [cbrd_pkg::DATA_W-1:0] rd_byte;
    logic                        command_strobe;
    logic [cbrd_pkg::DATA_W-1:0] command_value;
    logic                        latch_strobe;
    logic [cbrd_pkg::DATA_W-1:0] latch_value;
    logic                        test_strobe;
    logic [cbrd_pkg::DATA_W-1:0] test_value;
    logic [cbrd_pkg::SAM_W-1:0]  sam_state;
    logic                        map_type;
    logic                        reset_seen;
    logic [cbrd_pkg::POS_W-1:0]  index_now;
  } result_t;

  state_t                          state;
  state_t                          state_next;
  logic [cbrd_pkg::IMG_AW-1:0]     clear_addr;
  cbrd_pkg::cfg_t                  cfg;

  logic [cbrd_pkg::CMD_W-1:0]      item_cmd;
  logic [cbrd_pkg::ADDR_W-1:0]     item_addr;
  logic [cbrd_pkg::DATA_W-1:0]     item_data;
  logic [cbrd_pkg::POS_W-1:0]      item_pos;

  logic [cbrd_pkg::IDX_W-1:0]      buffer_index;
  logic [cbrd_pkg::IDX_W-1:0]      buffer_index_next;
  logic [cbrd_pkg::SAM_W-1:0]      sam_bits;
  logic [cbrd_pkg::SAM_W-1:0]      sam_bits_next;
  logic [cbrd_pkg::ADDR_W-1:0]     previous_address;
  logic [cbrd_pkg::DATA_W-1:0]     command_register;
  logic [cbrd_pkg::DATA_W-1:0]     command_register_next;
  logic [cbrd_pkg::DATA_W-1:0]     latch_register;
  logic [cbrd_pkg::DATA_W-1:0]     latch_register_next;
  logic [cbrd_pkg::DATA_W-1:0]     test_register;
  logic [cbrd_pkg::DATA_W-1:0]     test_register_next;

  logic                            rsp_valid;
  result_t                         rsp_q;
  result_t                         rsp_next;

  logic                            accept;
  logic                            exec_go;
  logic                            clearing;
  logic [cbrd_pkg::IDX_W-1:0]      idx_inc;

  // memory ports
  logic                            ri_en, ri_we, ri_wr;
  logic [cbrd_pkg::IMG_AW-1:0]     ri_addr, ri_waddr;
  logic [cbrd_pkg::DATA_W-1:0]     ri_wdata, ri_wval, ri_rdata;
  logic                            wi_en, wi_we, wi_wr;
  logic [cbrd_pkg::IMG_AW-1:0]     wi_addr;
  logic [cbrd_pkg::DATA_W-1:0]     wi_wdata, wi_wval, wi_rdata;
  logic                            buf_en, buf_we, buf_wr;
  logic [cbrd_pkg::BUF_AW-1:0]     buf_addr, buf_waddr;
  logic [cbrd_pkg::DATA_W-1:0]     buf_wdata, buf_rdata;

  assign clearing  = (state == S_CLEAR);
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign exec_go   = (state == S_EXEC) && (!rsp_valid || rsp.ready);
  assign idx_inc   = buffer_index + cbrd_pkg::IDX_W'(1);

  // ---- execute: read data from the memories is valid in S_EXEC ----
  always_comb begin
    logic [cbrd_pkg::ADDR_W-1:0] rv_next;
    logic [3:0]                  sam_bit;

    rv_next               = cfg.reset_vector + cbrd_pkg::ADDR_W'(1);
    sam_bit               = item_addr[4:1];
    buffer_index_next     = buffer_index;
    sam_bits_next         = sam_bits;
    command_register_next = command_register;
    latch_register_next   = latch_register;
    test_register_next    = test_register;
    rsp_next              = '0;
    ri_wr                 = 1'b0;
    ri_waddr              = cbrd_pkg::image_slot(item_addr);
    ri_wval               = item_data;
    wi_wr                 = 1'b0;
    wi_wval               = item_data;
    buf_wr                = 1'b0;
    buf_waddr             = buffer_index[cbrd_pkg::BUF_AW-1:0];

    case (item_cmd)
      cbrd_pkg::CMD_BUS_READ: begin
        rsp_next.rd_byte = ri_rdata;
        if (item_addr == cfg.read_data_address &&
            buffer_index != cbrd_pkg::IDX_W'(cbrd_pkg::BUFFER_SIZE)) begin
          buffer_index_next = idx_inc;
          if (int'(idx_inc) < cbrd_pkg::BUFFER_SIZE) begin
            // place the next buffer byte in the data-out slot
            ri_wr    = 1'b1;
            ri_waddr = cbrd_pkg::image_slot(cbrd_pkg::ADDR_W'(cfg.data_out_offset));
            ri_wval  = buf_rdata;
          end
        end
        if (item_addr == rv_next && previous_address == cfg.reset_vector) begin
          rsp_next.reset_seen = 1'b1;
          sam_bits_next       = '0;
        end
      end
      cbrd_pkg::CMD_BUS_WRITE: begin
        if (item_addr[cbrd_pkg::ADDR_W-1:5] == cbrd_pkg::SAM_PREFIX) begin
          sam_bits_next[sam_bit] = item_addr[0];
        end else if (item_addr == cfg.command_address) begin
          command_register_next   = item_data;
          rsp_next.command_strobe = 1'b1;
        end else if (item_addr == cfg.latch_address) begin
          latch_register_next   = item_data;
          rsp_next.latch_strobe = 1'b1;
        end else if (item_addr == cfg.write_data_address) begin
          if (buffer_index != cbrd_pkg::IDX_W'(cbrd_pkg::BUFFER_SIZE)) begin
            buf_wr            = 1'b1;
            buffer_index_next = idx_inc;
          end
        end else if (item_addr == cfg.test_address) begin
          test_register_next   = item_data;
          rsp_next.test_strobe = 1'b1;
          wi_wr                = 1'b1;
          wi_wval              = ~item_data;
        end else if ((item_addr & cfg.rom_base_bits) == cfg.rom_base_bits) begin
          wi_wr = 1'b1;
        end
      end
      cbrd_pkg::CMD_LOAD_READ: begin
        ri_wr = 1'b1;
      end
      cbrd_pkg::CMD_PEEK_WRITE: begin
        rsp_next.rd_byte = wi_rdata;
      end
      cbrd_pkg::CMD_LOAD_BUFFER: begin
        if (int'(item_pos) < cbrd_pkg::BUFFER_SIZE) begin
          buf_wr    = 1'b1;
          buf_waddr = cbrd_pkg::BUF_AW'(item_pos);
        end
      end
      cbrd_pkg::CMD_SET_INDEX: begin
        if (int'(item_pos) < cbrd_pkg::BUFFER_SIZE) begin
          buffer_index_next = cbrd_pkg::IDX_W'(item_pos);
        end else begin
          buffer_index_next = cbrd_pkg::IDX_W'(cbrd_pkg::BUFFER_SIZE);
        end
      end
      default: begin
      end
    endcase

    rsp_next.command_value = command_register_next;
    rsp_next.latch_value   = latch_register_next;
    rsp_next.test_value    = test_register_next;
    rsp_next.sam_state     = sam_bits_next;
    rsp_next.map_type      = sam_bits_next[cbrd_pkg::MAP_TYPE_BIT];
    rsp_next.index_now     = cbrd_pkg::POS_W'(buffer_index_next);
  end

  // ---- memory port muxes: reads at acceptance, writes at execute or clear ----
  always_comb begin
    ri_we    = clearing || (exec_go && ri_wr);
    ri_en    = accept || ri_we;
    ri_wdata = clearing ? cbrd_pkg::IMAGE_FILL : ri_wval;
    if (clearing) begin
      ri_addr = clear_addr;
    end else if (state == S_IDLE) begin
      ri_addr = cbrd_pkg::image_slot(req.address);
    end else begin
      ri_addr = ri_waddr;
    end

    wi_we    = clearing || (exec_go && wi_wr);
    wi_en    = accept || wi_we;
    wi_wdata = clearing ? cbrd_pkg::IMAGE_FILL : wi_wval;
    if (clearing) begin
      wi_addr = clear_addr;
    end else if (state == S_IDLE) begin
      wi_addr = cbrd_pkg::image_slot(req.address);
    end else begin
      wi_addr = cbrd_pkg::image_slot(item_addr);
    end

    buf_we    = exec_go && buf_wr;
    buf_en    = accept || buf_we;
    buf_wdata = item_data;
    buf_addr  = (state == S_IDLE) ? idx_inc[cbrd_pkg::BUF_AW-1:0] : buf_waddr;
  end

  cbrd_ram #(.DEPTH(cbrd_pkg::IMAGE_SIZE), .WIDTH(cbrd_pkg::DATA_W)) u_read_image (
    .clk   (clk),
    .en    (ri_en),
    .we    (ri_we),
    .addr  (ri_addr),
    .wdata (ri_wdata),
    .rdata (ri_rdata)
  );

  cbrd_ram #(.DEPTH(cbrd_pkg::IMAGE_SIZE), .WIDTH(cbrd_pkg::DATA_W)) u_write_image (
    .clk   (clk),
    .en    (wi_en),
    .we    (wi_we),
    .addr  (wi_addr),
    .wdata (wi_wdata),
    .rdata (wi_rdata)
  );

  cbrd_ram #(.DEPTH(cbrd_pkg::BUFFER_SIZE), .WIDTH(cbrd_pkg::DATA_W)) u_data_buffer (
    .clk   (clk),
    .en    (buf_en),
    .we    (buf_we),
    .addr  (buf_addr),
    .wdata (buf_wdata),
    .rdata (buf_rdata)
  );

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clear_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clear_addr <= clear_addr + cbrd_pkg::IMG_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd  <= req.cmd;
      item_addr <= req.address;
      item_data <= req.data;
      item_pos  <= req.buffer_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_index     <= '0;
      sam_bits         <= '0;
      previous_address <= '0;
      command_register <= '0;
      latch_register   <= '0;
      test_register    <= '0;
    end else if (exec_go) begin
      buffer_index     <= buffer_index_next;
      sam_bits         <= sam_bits_next;
      command_register <= command_register_next;
      latch_register   <= latch_register_next;
      test_register    <= test_register_next;
      // host commands and the idle bus address leave it alone
      if ((item_cmd == cbrd_pkg::CMD_BUS_READ || item_cmd == cbrd_pkg::CMD_BUS_WRITE) &&
          item_addr != cbrd_pkg::NO_TRACK) begin
        previous_address <= item_addr;
      end
    end
  end

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= cbrd_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cbrd_pkg::CFG_COMMAND_ADDRESS:    cfg.command_address    <= cfg_data;
        cbrd_pkg::CFG_LATCH_ADDRESS:      cfg.latch_address      <= cfg_data;
        cbrd_pkg::CFG_WRITE_DATA_ADDRESS: cfg.write_data_address <= cfg_data;
        cbrd_pkg::CFG_READ_DATA_ADDRESS:  cfg.read_data_address  <= cfg_data;
        cbrd_pkg::CFG_TEST_ADDRESS:       cfg.test_address       <= cfg_data;
        cbrd_pkg::CFG_DATA_OUT_OFFSET: begin
          cfg.data_out_offset <= cfg_data[cbrd_pkg::OFFSET_W-1:0];
        end
        cbrd_pkg::CFG_ROM_BASE_BITS:      cfg.rom_base_bits      <= cfg_data;
        cbrd_pkg::CFG_RESET_VECTOR:       cfg.reset_vector       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.rd_byte        = rsp_q.rd_byte;
  assign rsp.command_strobe = rsp_q.command_strobe;
  assign rsp.command_value  = rsp_q.command_value;
  assign rsp.latch_strobe   = rsp_q.latch_strobe;
  assign rsp.latch_value    = rsp_q.latch_value;
  assign rsp.test_strobe    = rsp_q.test_strobe;
  assign rsp.test_value     = rsp_q.test_value;
  assign rsp.sam_state      = rsp_q.sam_state;
  assign rsp.map_type       = rsp_q.map_type;
  assign rsp.reset_seen     = rsp_q.reset_seen;
  assign rsp.index_now      = rsp_q.index_now;

  // ---- assertions ----
  `CBRD_ASSERT_NEXT(a_accept_to_exec, accept, state == S_EXEC)
  `CBRD_ASSERT_SAME(a_index_bound, 1'b1, buffer_index <= cbrd_pkg::IDX_W'(cbrd_pkg::BUFFER_SIZE))
  `CBRD_ASSERT_SAME(a_one_strobe, rsp_valid, $onehot0({rsp_q.command_strobe, rsp_q.latch_strobe, rsp_q.test_strobe}))
  `CBRD_ASSERT_SAME(a_reset_clears_sam, rsp_valid && rsp_q.reset_seen, rsp_q.sam_state == '0)
  `CBRD_ASSERT_SAME(a_no_write_in_idle, state == S_IDLE, !buf_we && !(ri_we || wi_we))

endmodule

FILE: rtl/cbrd_ram.sv
// ----------------------------------------------------------------------------
// cbrd_ram
// Single-port synchronous RAM, registered read, write takes the port.
// ----------------------------------------------------------------------------
module cbrd_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
